// File: design/trle_pkg.sv
// Package for the TGA run-length pixel decoder: beat types, job type,
// register indexes and packet constants. No dependencies.
`default_nettype none

package trle_pkg;

  localparam int unsigned QueueDepthDefault = 2;

  localparam int unsigned CfgIndexWidth = 2;
  localparam logic [CfgIndexWidth-1:0] CfgBytesPerPixel = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CfgImagePixels   = 2'd1;

  localparam logic [2:0]  BppReset  = 3'd3;
  localparam logic [7:0]  HdrRunBit = 8'd128;
  localparam logic [7:0]  RunBias   = 8'd127;
  localparam logic [24:0] EmitMax   = 25'h1FFFFFF;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       frame_start;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] pixel_first;
    logic [31:0] pixel_second;
    logic [1:0]  pair_count;
    logic        run_last;
    logic        image_done;
  } out_beat_t;

  // One completed pixel and how many times it is to be emitted.
  typedef struct packed {
    logic [31:0] pixel;
    logic [7:0]  count;
    logic [24:0] base;
  } job_t;

endpackage

`default_nettype wire

// File: design/trle_front.sv
// Front end: parses packet headers, assembles pixel bytes and issues jobs.
// Depends on trle_pkg.
`default_nettype none

module trle_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  trle_pkg::in_beat_t in_data,
  input  logic [2:0]       bytes_per_pixel,
  input  logic [24:0]      image_pixels,
  output logic             push,
  output trle_pkg::job_t   job
);
  import trle_pkg::*;

  logic        expect_header, expect_header_next;
  logic        packet_is_run, packet_is_run_next;
  logic [7:0]  pixels_left, pixels_left_next;
  logic [1:0]  byte_position, byte_position_next;
  logic [31:0] pixel_assembly, pixel_assembly_next;
  logic [24:0] pixels_emitted, pixels_emitted_next;

  logic        cur_expect, cur_run, fs;
  logic [7:0]  cur_left, b, hdr_left, left_after;
  logic [1:0]  cur_pos;
  logic [31:0] cur_asm, asm_new;
  logic [24:0] cur_emit;
  logic [25:0] emit_sum;
  logic [2:0]  eff_bpp;

  assign fs = in_data.frame_start;
  assign b  = in_data.byte_in;

  always_comb begin
    eff_bpp = (bytes_per_pixel == 3'd0) ? 3'd1 :
              (bytes_per_pixel > 3'd4)  ? 3'd4 : bytes_per_pixel;
  end

  always_comb begin
    // Frame start clears state before the byte is used.
    cur_expect = fs | expect_header;
    cur_run    = !fs & packet_is_run;
    cur_left   = fs ? 8'd0 : pixels_left;
    cur_pos    = fs ? 2'd0 : byte_position;
    cur_asm    = fs ? 32'd0 : pixel_assembly;
    cur_emit   = fs ? 25'd0 : pixels_emitted;

    hdr_left   = b[7] ? (b - RunBias) : (b + 8'd1);
    asm_new    = cur_asm | ({24'd0, b} << {cur_pos, 3'b000});

    expect_header_next  = cur_expect;
    packet_is_run_next  = cur_run;
    pixels_left_next    = cur_left;
    byte_position_next  = cur_pos;
    pixel_assembly_next = cur_asm;
    pixels_emitted_next = cur_emit;

    push       = 1'b0;
    job.pixel  = asm_new;
    job.count  = cur_run ? cur_left : 8'd1;
    job.base   = cur_emit;
    emit_sum   = {1'b0, cur_emit} + {18'd0, job.count};
    left_after = cur_run ? 8'd0 : ((cur_left != 8'd0) ? cur_left - 8'd1 : 8'd0);

    if (cur_expect) begin
      if (cur_emit < image_pixels) begin
        packet_is_run_next  = (b >= HdrRunBit);
        pixels_left_next    = hdr_left;
        expect_header_next  = 1'b0;
        byte_position_next  = 2'd0;
        pixel_assembly_next = 32'd0;
      end
    end else if (({1'b0, cur_pos} + 3'd1) < eff_bpp) begin
      byte_position_next  = cur_pos + 2'd1;
      pixel_assembly_next = asm_new;
    end else begin
      byte_position_next  = 2'd0;
      pixel_assembly_next = 32'd0;
      pixels_left_next    = left_after;
      expect_header_next  = (left_after == 8'd0);
      if (job.count != 8'd0) begin
        push = accept;
        pixels_emitted_next = emit_sum[25] ? EmitMax : emit_sum[24:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_header  <= 1'b1;
      packet_is_run  <= 1'b0;
      pixels_left    <= 8'd0;
      byte_position  <= 2'd0;
      pixel_assembly <= 32'd0;
      pixels_emitted <= 25'd0;
    end else if (accept) begin
      expect_header  <= expect_header_next;
      packet_is_run  <= packet_is_run_next;
      pixels_left    <= pixels_left_next;
      byte_position  <= byte_position_next;
      pixel_assembly <= pixel_assembly_next;
      pixels_emitted <= pixels_emitted_next;
    end
  end

endmodule

`default_nettype wire

// File: design/trle_queue.sv
// Small job queue between the front end and the back end.
// Depends on trle_pkg.
`default_nettype none

module trle_queue #(
  parameter int unsigned Depth = trle_pkg::QueueDepthDefault
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  trle_pkg::job_t push_data,
  input  logic           pop,
  output trle_pkg::job_t pop_data,
  output logic           full,
  output logic           nonempty
);
  import trle_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  job_t            slots [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  assign full     = (count == CntW'(Depth));
  assign nonempty = (count != '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop)) else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !nonempty)) else $error("job queue underflow");

endmodule

`default_nettype wire

// File: design/trle_back.sv
// Back end: expands each job into one- or two-pixel result beats and
// tracks the emitted pixel count. Depends on trle_pkg.
`default_nettype none

module trle_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_avail,
  input  trle_pkg::job_t     job,
  output logic               pop,
  input  logic [24:0]        image_pixels,
  output logic               out_valid,
  input  logic               out_ready,
  output trle_pkg::out_beat_t out_data
);
  import trle_pkg::*;

  logic        active;
  logic [7:0]  left;
  logic [31:0] pix;
  logic [24:0] emitted;

  logic        emit;
  logic [1:0]  cnt;
  logic [7:0]  left_next;
  logic [25:0] emit_sum;
  logic [24:0] emitted_next;

  assign pop  = !active && job_avail;
  assign emit = active && (!out_valid || out_ready);

  always_comb begin
    cnt          = (left >= 8'd2) ? 2'd2 : 2'd1;
    left_next    = left - {6'd0, cnt};
    emit_sum     = {1'b0, emitted} + {24'd0, cnt};
    emitted_next = emit_sum[25] ? EmitMax : emit_sum[24:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        active <= 1'b1;
      end else if (emit && left_next == 8'd0) begin
        active <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      left    <= job.count;
      pix     <= job.pixel;
      emitted <= job.base;
    end else if (emit) begin
      left    <= left_next;
      emitted <= emitted_next;
    end
    if (emit) begin
      out_data.pixel_first  <= pix;
      out_data.pixel_second <= (cnt == 2'd2) ? pix : 32'd0;
      out_data.pair_count   <= cnt;
      out_data.run_last     <= (left_next == 8'd0);
      out_data.image_done   <= (emitted_next >= image_pixels);
    end
  end

  a_active_has_work: assert property (@(posedge clk) disable iff (rst)
    active |-> (left != 8'd0)) else $error("active job with no pixels left");

  a_last_ends_job: assert property (@(posedge clk) disable iff (rst)
    (emit && left_next == 8'd0) |=> !active) else $error("job did not end on last beat");

endmodule

`default_nettype wire

// File: design/tga_rle_pixel_decoder.sv
// Top level of the TGA run-length pixel decoder: configuration registers,
// front end, job queue and back end. Depends on trle_pkg and trle_* modules.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    in_data (byte_in, frame_start)
//   out      output     out_valid / out_ready  out_data (pixels, count, flags)
//   cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A completed pixel becomes a job; the back end loads the job and then emits an
// N-pixel run as two-pixel beats, with a one-pixel beat last when N is odd (a
// raw pixel gives a single one-pixel beat). Input stalls when the job queue
// (QueueDepth entries) is full. Synchronous reset clears all control state;
// cfg_ready is always high.
`default_nettype none

module tga_rle_pixel_decoder #(
  parameter int unsigned QueueDepth = trle_pkg::QueueDepthDefault
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  trle_pkg::in_beat_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output trle_pkg::out_beat_t                  out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [trle_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  logic [24:0]                          cfg_data
);
  import trle_pkg::*;

  logic [2:0]  bytes_per_pixel;
  logic [24:0] image_pixels;

  logic q_full, q_nonempty, push, pop;
  job_t push_job, pop_job;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_pixel <= BppReset;
      image_pixels    <= 25'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CfgBytesPerPixel: bytes_per_pixel <= cfg_data[2:0];
        CfgImagePixels:   image_pixels    <= cfg_data;
        default: ;
      endcase
    end
  end

  trle_front u_front (
    .clk             (clk),
    .rst             (rst),
    .accept          (in_valid && in_ready),
    .in_data         (in_data),
    .bytes_per_pixel (bytes_per_pixel),
    .image_pixels    (image_pixels),
    .push            (push),
    .job             (push_job)
  );

  trle_queue #(.Depth(QueueDepth)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_job),
    .pop       (pop),
    .pop_data  (pop_job),
    .full      (q_full),
    .nonempty  (q_nonempty)
  );

  trle_back u_back (
    .clk          (clk),
    .rst          (rst),
    .job_avail    (q_nonempty),
    .job          (pop_job),
    .pop          (pop),
    .image_pixels (image_pixels),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

endmodule

`default_nettype wire
